>>> design/olad_pkg.sv
package olad_pkg;

  localparam int CAPACITY = 16;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] data_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               entry_valid;
    logic               last;
  } result_t;

  typedef struct packed {
    logic append;
    logic del;
    logic rotate;
  } cell_ctrl_t;

endpackage

>>> design/ordered_list_append_delete.sv
// channel  ports                  handshake
// cmd      cmd (action, value)    taken when start is high and busy is low
// result   result (status, entry) valid for one cycle while strobe is high
//
// append, delete and unused codes: one result in the cycle after the item is taken
// dump: one result per entry on consecutive cycles, busy high while the dump runs
// dump of an empty list: one result in the cycle after the item is taken
// the dump length is set by the entry count; the cell chain rotates, one entry a cycle
// rst is synchronous and empties the list; the receiver cannot stall results
module ordered_list_append_delete #(
  parameter int CAPACITY = olad_pkg::CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  olad_pkg::cmd_t    cmd,
  output logic              strobe,
  output olad_pkg::result_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     remaining, remaining_next;
  logic                 strobe_next;
  olad_pkg::result_t    result_next;
  olad_pkg::cell_ctrl_t ctrl;
  logic                 accept;
  logic                 full;

  logic signed [31:0]   value [CAPACITY];
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY:0]    found;

  assign accept      = start && !busy;
  assign busy        = state == S_DUMP;
  assign full        = count == CNT_W'(CAPACITY);
  assign ctrl.append = accept && (cmd.action == olad_pkg::ACT_APPEND) && !full;
  assign ctrl.del    = accept && (cmd.action == olad_pkg::ACT_DELETE);
  assign ctrl.rotate = state == S_DUMP;
  assign found[0]    = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] nbr_value;
    logic               nbr_occ;
    if (i == CAPACITY - 1) begin : g_tail
      assign nbr_value = '0;
      assign nbr_occ   = 1'b0;
    end else begin : g_mid
      assign nbr_value = value[i+1];
      assign nbr_occ   = occ[i+1];
    end
    olad_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .key        (cmd.data_value),
      .nbr_value  (nbr_value),
      .nbr_occ    (nbr_occ),
      .head_value (value[0]),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .occ        (occ[i]),
      .value      (value[i])
    );
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    strobe_next    = 1'b0;
    result_next    = '0;
    result_next.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          case (cmd.action)
            olad_pkg::ACT_APPEND: begin
              if (full) begin
                result_next.status = olad_pkg::ST_FULL;
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
            olad_pkg::ACT_DELETE: begin
              if (count == '0) begin
                result_next.status = olad_pkg::ST_EMPTY;
              end else if (found[CAPACITY]) begin
                count_next = count - CNT_W'(1);
              end else begin
                result_next.status = olad_pkg::ST_NOT_FOUND;
              end
            end
            olad_pkg::ACT_DUMP: begin
              if (count != '0) begin
                strobe_next    = 1'b0;
                remaining_next = count;
                state_next     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        strobe_next             = 1'b1;
        result_next.entry_value = value[0];
        result_next.entry_valid = 1'b1;
        result_next.last        = remaining == CNT_W'(1);
        remaining_next          = remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      strobe    <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action != olad_pkg::ACT_DUMP) |=> strobe && result.last)
    else $error("missing result for append or delete");

  a_dump_stream: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.entry_valid)
    else $error("dump stream broken");

  a_dump_remaining: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remaining != '0) && (remaining <= count))
    else $error("dump counter out of range");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("list changed during dump");

endmodule

>>> design/olad_cell.sv
module olad_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                      clk,
  input  olad_pkg::cell_ctrl_t      ctrl,
  input  logic [CNT_W-1:0]          count,
  input  logic signed [31:0]        key,
  input  logic signed [31:0]        nbr_value,
  input  logic                      nbr_occ,
  input  logic signed [31:0]        head_value,
  input  logic                      found_in,
  output logic                      found_out,
  output logic                      occ,
  output logic signed [31:0]        value
);

  logic match;

  assign occ       = count > CNT_W'(INDEX);
  assign match     = occ && (value == key);
  assign found_out = found_in || match;

  always_ff @(posedge clk) begin
    if (ctrl.append && (count == CNT_W'(INDEX))) begin
      value <= key;
    end else if (ctrl.del && found_out) begin
      value <= nbr_value;
    end else if (ctrl.rotate && occ) begin
      value <= nbr_occ ? nbr_value : head_value;
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  import olad_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int N_ROWS = 21;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] value;
    int          reps;
    logic        pinned;
    logic [1:0]  pin_st;
  } row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  // typed status for directed rows, travels with the item
  logic       pin_valid = 1'b0;
  logic [1:0] pin_status = ST_OK;

  logic signed [31:0] list_mem [CAPACITY];
  int                 list_len = 0;
  result_t            due_results [$];
  int                 bad_count = 0;
  int                 burst_left = 0;

  row_t script [N_ROWS] = '{
    '{ACT_DUMP,   32'h0000_0000, 1, 1'b1, ST_OK},
    '{ACT_DELETE, 32'h0000_0005, 1, 1'b1, ST_EMPTY},
    '{ACT_UNUSED, 32'h0000_0000, 1, 1'b1, ST_OK},
    '{ACT_APPEND, 32'h8000_0000, 1, 1'b1, ST_OK},
    '{ACT_APPEND, 32'h7fff_ffff, 1, 1'b1, ST_OK},
    '{ACT_APPEND, 32'h0000_0000, 1, 1'b1, ST_OK},
    '{ACT_APPEND, 32'hffff_ffff, 1, 1'b1, ST_OK},
    '{ACT_APPEND, 32'h0000_0007, 1, 1'b0, ST_OK},
    '{ACT_APPEND, 32'h8000_0000, 1, 1'b0, ST_OK},
    '{ACT_DELETE, 32'h0000_04d2, 1, 1'b1, ST_NOT_FOUND},
    '{ACT_DELETE, 32'h8000_0000, 1, 1'b0, ST_OK},
    '{ACT_DUMP,   32'h0000_0000, 1, 1'b0, ST_OK},
    '{ACT_APPEND, 32'h55aa_55aa, CAPACITY - 5, 1'b1, ST_OK},
    '{ACT_APPEND, 32'h0000_0001, 1, 1'b1, ST_FULL},
    '{ACT_DUMP,   32'hffff_ffff, 1, 1'b0, ST_OK},
    '{ACT_DELETE, 32'h7fff_ffff, 1, 1'b0, ST_OK},
    '{ACT_DELETE, 32'h8000_0000, 1, 1'b0, ST_OK},
    '{ACT_APPEND, 32'h0000_0001, 1, 1'b0, ST_OK},
    '{ACT_DELETE, 32'h0000_0001, 1, 1'b0, ST_OK},
    '{ACT_UNUSED, 32'hffff_ffff, 1, 1'b1, ST_OK},
    '{ACT_DUMP,   32'h0000_0000, 1, 1'b0, ST_OK}
  };

  ordered_list_append_delete DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic list_apply(input cmd_t c, input logic pinned, input logic [1:0] pin_st);
    result_t    r;
    logic [1:0] st;
    int         hit;
    r = '0;
    st = ST_OK;
    hit = -1;
    if (c.action == ACT_DUMP && list_len > 0) begin
      for (int i = 0; i < list_len; i++) begin
        r.status = pinned ? pin_st : ST_OK;
        r.entry_value = list_mem[i];
        r.entry_valid = 1'b1;
        r.last = (i == list_len - 1);
        due_results.push_back(r);
      end
    end else begin
      case (c.action)
        ACT_APPEND: begin
          if (list_len >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            list_mem[list_len] = c.data_value;
            list_len++;
          end
        end
        ACT_DELETE: begin
          if (list_len == 0) begin
            st = ST_EMPTY;
          end else begin
            for (int i = 0; i < list_len; i++)
              if (hit < 0 && list_mem[i] == c.data_value) hit = i;
            if (hit < 0) begin
              st = ST_NOT_FOUND;
            end else begin
              for (int j = hit; j + 1 < list_len; j++) list_mem[j] = list_mem[j + 1];
              list_len--;
            end
          end
        end
        default: st = ST_OK;
      endcase
      r.status = pinned ? pin_st : st;
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endtask

  task automatic report_bad(input string what, input result_t want, input result_t got);
    bad_count++;
    if (bad_count <= 10)
      $display("%s: want st=%0d val=%0d vld=%0b last=%0b got st=%0d val=%0d vld=%0b last=%0b",
               what, want.status, want.entry_value, want.entry_valid, want.last,
               got.status, got.entry_value, got.entry_valid, got.last);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (strobe) begin
        if (due_results.size() == 0) begin
          report_bad("unexpected result", '0, result);
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status || result.entry_value !== want.entry_value ||
              result.entry_valid !== want.entry_valid || result.last !== want.last)
            report_bad("mismatch", want, result);
        end
      end
      if (start && !busy) list_apply(cmd, pin_valid, pin_status);
    end
  end

  task automatic send_item(input cmd_t c, input logic pinned, input logic [1:0] pin_st);
    start <= 1'b1;
    cmd <= c;
    pin_valid <= pinned;
    pin_status <= pin_st;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 7)) - 32'd3;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)] : $urandom;
    endcase
  endfunction

  initial begin
    cmd_t c;
    int   append_pct;
    int   roll;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (script[k]) begin
      c.action = script[k].action;
      c.data_value = script[k].value;
      repeat (script[k].reps) send_item(c, script[k].pinned, script[k].pin_st);
    end
    // chunks lean toward filling or draining the list
    for (int chunk = 0; chunk < 12; chunk++) begin
      append_pct = $urandom_range(15, 85);
      repeat (33) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          c.action = ACT_UNUSED;
          c.data_value = $urandom;
        end else if (roll < 18) begin
          c.action = ACT_DUMP;
          c.data_value = $urandom;
        end else if ($urandom_range(0, 99) < append_pct) begin
          c.action = ACT_APPEND;
          c.data_value = pick_value();
        end else begin
          c.action = ACT_DELETE;
          if (list_len > 0 && $urandom_range(0, 99) < 60)
            c.data_value = list_mem[$urandom_range(0, list_len - 1)];
          else
            c.data_value = pick_value();
        end
        send_item(c, 1'b0, ST_OK);
      end
    end
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (bad_count == 0 && due_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
design/olad_pkg.sv
design/olad_cell.sv
design/ordered_list_append_delete.sv
tb/tb.sv
